// File: rtl/calibrated_compass_heading_assert.svh
// Assertion macros for the compass heading block.
// Included by the top level; no other dependencies.
`ifndef CALIBRATED_COMPASS_HEADING_ASSERT_SVH
`define CALIBRATED_COMPASS_HEADING_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CCH_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("calibrated_compass_heading: check failed");

// Next-cycle implication, disabled during reset.
`define CCH_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("calibrated_compass_heading: check failed");

`endif

// File: rtl/cch_pkg.sv
// Constants, register indexes and the arctangent table for the compass heading block.
// No dependencies.
package cch_pkg;

    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ANGLE_TABLE_LEN   = 24;

    localparam int HEADING_W = 16;
    localparam int DECL_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_X_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DECL  = 3'd4;

    localparam logic [DECL_W-1:0] DECL_RESET = 16'd1248;

    // Vector path width: normalized magnitude sits at bit NORM_BIT, plus CORDIC gain.
    localparam int CORDIC_W  = 57;
    localparam int NORM_BIT  = 52;
    localparam int NORM_TOP  = NORM_BIT + 1;
    localparam int NORM_FIRST = 32;

    // Angles in 1/256 centidegree.
    localparam int ANGLE_W    = 25;
    localparam int FRAC_BITS  = 8;
    localparam int ROUND_HALF = 128;
    localparam int FULL_CDEG  = 36000;
    localparam int HALF_CDEG  = 18000;
    localparam int HALF_ANGLE = HALF_CDEG * 256;

    localparam logic signed [ANGLE_W-1:0] ATAN_TABLE [ANGLE_TABLE_LEN] = '{
        25'sd1152000, 25'sd680065, 25'sd359328, 25'sd182400,
        25'sd91554,   25'sd45822,  25'sd22916,  25'sd11459,
        25'sd5730,    25'sd2865,   25'sd1432,   25'sd716,
        25'sd358,     25'sd179,    25'sd90,     25'sd45,
        25'sd22,      25'sd11,     25'sd6,      25'sd3,
        25'sd1,       25'sd1,      25'sd0,      25'sd0
    };

endpackage

// File: rtl/calibrated_compass_heading.sv
// Calibrated compass heading: one raw X/Y magnetometer beat in, one heading beat out.
// Depends on cch_pkg and calibrated_compass_heading_assert.svh. Each axis loses the
// midpoint of its calibration min and max, the axes are cross-scaled by the spans,
// and a pipelined vectoring CORDIC gives atan2 in centidegrees, after which the
// declination is added. The block takes one beat per clock cycle while the output is
// not stalled; the CORDIC pipeline has one register stage per iteration, and a stall at
// the output holds every stage. No clearing pass follows reset.
module calibrated_compass_heading #(
    parameter int SAMPLE_BITS   = cch_pkg::SAMPLE_BITS_DEF,
    parameter int CORDIC_STAGES = cch_pkg::CORDIC_STAGES_DEF,
    localparam int S_TDATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W = ((cch_pkg::HEADING_W + 2 * (SAMPLE_BITS + 1) + 7) / 8) * 8,
    localparam int CFG_W     = (SAMPLE_BITS > cch_pkg::DECL_W) ? SAMPLE_BITS
                                                               : cch_pkg::DECL_W
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [S_TDATA_W-1:0]           s_tdata,   // mag_x, mag_y
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [M_TDATA_W-1:0]           m_tdata,   // heading_cdeg, offset_x, offset_y
    output logic                           m_tuser,   // cal_error
    input  logic                           cfg_wr_en,
    input  logic [cch_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]               cfg_wdata
);
    import cch_pkg::*;

    localparam int W        = SAMPLE_BITS;
    localparam int CW       = CORDIC_W;
    localparam int PW       = 2 * W + 2;
    localparam int NUM_ITER = (CORDIC_STAGES < ANGLE_TABLE_LEN) ? CORDIC_STAGES
                                                                 : ANGLE_TABLE_LEN;
    localparam int D        = NUM_ITER + 8;
    localparam int HQ_W     = ANGLE_W + 1 - FRAC_BITS;

    // configuration
    logic signed [W-1:0]  x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    logic [DECL_W-1:0]    decl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_min_reg <= {1'b1, {(W-1){1'b0}}};
            x_max_reg <= {1'b0, {(W-1){1'b1}}};
            y_min_reg <= {1'b1, {(W-1){1'b0}}};
            y_max_reg <= {1'b0, {(W-1){1'b1}}};
            decl_reg  <= DECL_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_X_MIN: x_min_reg <= cfg_wdata[W-1:0];
                REG_X_MAX: x_max_reg <= cfg_wdata[W-1:0];
                REG_Y_MIN: y_min_reg <= cfg_wdata[W-1:0];
                REG_Y_MAX: y_max_reg <= cfg_wdata[W-1:0];
                REG_DECL:  decl_reg  <= cfg_wdata[DECL_W-1:0];
                default: ;
            endcase
        end
    end

    logic adv;
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // stage 1: offsets, spans, error
    logic signed [W-1:0]   mx, my;
    logic signed [W:0]     sum_x, sum_y, spx_next, spy_next;
    logic signed [W+1:0]   dx, dy, dx_adj, dy_adj;
    logic signed [W:0]     ox_next, oy_next;
    logic                  err_next, zero_next;

    always_comb begin
        mx       = s_tdata[W-1:0];
        my       = s_tdata[2*W-1:W];
        sum_x    = {x_min_reg[W-1], x_min_reg} + {x_max_reg[W-1], x_max_reg};
        sum_y    = {y_min_reg[W-1], y_min_reg} + {y_max_reg[W-1], y_max_reg};
        dx       = {mx[W-1], mx, 1'b0} - {sum_x[W], sum_x};
        dy       = {my[W-1], my, 1'b0} - {sum_y[W], sum_y};
        dx_adj   = dx + {{(W+1){1'b0}}, dx[W+1]};
        dy_adj   = dy + {{(W+1){1'b0}}, dy[W+1]};
        ox_next  = dx_adj[W+1:1];
        oy_next  = dy_adj[W+1:1];
        spx_next = {x_max_reg[W-1], x_max_reg} - {x_min_reg[W-1], x_min_reg};
        spy_next = {y_max_reg[W-1], y_max_reg} - {y_min_reg[W-1], y_min_reg};
        err_next = spx_next[W] || (spx_next == '0) || spy_next[W] || (spy_next == '0);
        zero_next = (ox_next == '0) && (oy_next == '0);
    end

    // side chain carried with every stage
    logic [D:1]           vld_reg;
    logic signed [W:0]    ox_reg [1:D];
    logic signed [W:0]    oy_reg [1:D];
    logic                 err_reg [1:D];
    logic                 zero_reg [1:D];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[D-1:1], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ox_reg[1]   <= ox_next;
            oy_reg[1]   <= oy_next;
            err_reg[1]  <= err_next;
            zero_reg[1] <= zero_next;
            for (int k = 2; k <= D; k++) begin
                ox_reg[k]   <= ox_reg[k-1];
                oy_reg[k]   <= oy_reg[k-1];
                err_reg[k]  <= err_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end
        end
    end

    logic signed [W:0] spx_reg, spy_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            spx_reg <= spx_next;
            spy_reg <= spy_next;
        end
    end

    // stage 2: cross-scaling products
    logic signed [PW-1:0] px_reg, py_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            px_reg <= ox_reg[1] * spy_reg;
            py_reg <= oy_reg[1] * spx_reg;
        end
    end

    // stage 3: fold into the right half plane
    logic signed [CW-1:0] pxe, pye;
    logic signed [CW-1:0] x3_reg, y3_reg;
    logic                 neg3_reg;

    always_comb begin
        pxe = {{(CW-PW){px_reg[PW-1]}}, px_reg};
        pye = {{(CW-PW){py_reg[PW-1]}}, py_reg};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            neg3_reg <= px_reg[PW-1];
            x3_reg   <= px_reg[PW-1] ? -pxe : pxe;
            y3_reg   <= px_reg[PW-1] ? -pye : pye;
        end
    end

    // stage 4: magnitude
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] x4_reg, y4_reg;
    logic [CW-1:0]        mag4_reg;
    logic                 neg4_reg;

    assign ay = y3_reg[CW-1] ? -y3_reg : y3_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            x4_reg   <= x3_reg;
            y4_reg   <= y3_reg;
            neg4_reg <= neg3_reg;
            mag4_reg <= (x3_reg > ay) ? x3_reg : ay;
        end
    end

    // stages 5 and 6: normalize, three shift steps each
    logic [CW-1:0] mag_a, mag_b;
    logic [CW-1:0] xa_next, ya_next, xb_next, yb_next;
    logic [CW-1:0] x5_reg, y5_reg, mag5_reg;
    logic          neg5_reg;

    always_comb begin
        xa_next = x4_reg;
        ya_next = y4_reg;
        mag_a   = mag4_reg;
        for (int j = 0; j < 3; j++) begin
            if (mag_a < (CW'(1) << (NORM_TOP - (NORM_FIRST >> j)))) begin
                xa_next = xa_next << (NORM_FIRST >> j);
                ya_next = ya_next << (NORM_FIRST >> j);
                mag_a   = mag_a << (NORM_FIRST >> j);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x5_reg   <= xa_next;
            y5_reg   <= ya_next;
            mag5_reg <= mag_a;
            neg5_reg <= neg4_reg;
        end
    end

    always_comb begin
        xb_next = x5_reg;
        yb_next = y5_reg;
        mag_b   = mag5_reg;
        for (int j = 3; j < 6; j++) begin
            if (mag_b < (CW'(1) << (NORM_TOP - (NORM_FIRST >> j)))) begin
                xb_next = xb_next << (NORM_FIRST >> j);
                yb_next = yb_next << (NORM_FIRST >> j);
                mag_b   = mag_b << (NORM_FIRST >> j);
            end
        end
    end

    // CORDIC: entry 0 is stage 6, one iteration per stage after it
    logic signed [CW-1:0]      cx_reg [0:NUM_ITER];
    logic signed [CW-1:0]      cy_reg [0:NUM_ITER];
    logic signed [ANGLE_W-1:0] ca_reg [0:NUM_ITER];

    always_ff @(posedge aclk) begin
        if (adv) begin
            cx_reg[0] <= xb_next;
            cy_reg[0] <= yb_next;
            ca_reg[0] <= neg5_reg ? ANGLE_W'(HALF_ANGLE) : '0;
            for (int k = 0; k < NUM_ITER; k++) begin
                if (!cy_reg[k][CW-1]) begin
                    cx_reg[k+1] <= cx_reg[k] + (cy_reg[k] >>> k);
                    cy_reg[k+1] <= cy_reg[k] - (cx_reg[k] >>> k);
                    ca_reg[k+1] <= ca_reg[k] + ATAN_TABLE[k];
                end else begin
                    cx_reg[k+1] <= cx_reg[k] - (cy_reg[k] >>> k);
                    cy_reg[k+1] <= cy_reg[k] + (cx_reg[k] >>> k);
                    ca_reg[k+1] <= ca_reg[k] - ATAN_TABLE[k];
                end
            end
        end
    end

    // round to centidegrees and wrap into 0..35999
    logic signed [ANGLE_W:0]  ang_rnd;
    logic signed [HQ_W-1:0]   hq, hw;
    logic [HEADING_W-1:0]     hd_next, hd_reg;

    always_comb begin
        ang_rnd = {ca_reg[NUM_ITER][ANGLE_W-1], ca_reg[NUM_ITER]}
                + (ANGLE_W+1)'(ROUND_HALF);
        hq      = ang_rnd[ANGLE_W:FRAC_BITS];
        priority if (hq[HQ_W-1]) begin
            hw = hq + HQ_W'(FULL_CDEG);
        end else if (hq >= HQ_W'(FULL_CDEG)) begin
            hw = hq - HQ_W'(FULL_CDEG);
        end else begin
            hw = hq;
        end
        hd_next = zero_reg[D-2] ? '0 : hw[HEADING_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hd_reg <= hd_next;
        end
    end

    // declination and output register
    logic [HEADING_W:0]    hsum;
    logic [HEADING_W-1:0]  heading_next, heading_reg;

    always_comb begin
        hsum = {1'b0, hd_reg} + {1'b0, decl_reg};
        if (hsum > (HEADING_W+1)'(FULL_CDEG)) begin
            hsum = hsum - (HEADING_W+1)'(FULL_CDEG);
        end
        heading_next = err_reg[D-1] ? '0 : hsum[HEADING_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            heading_reg <= heading_next;
        end
    end

    assign m_tvalid = vld_reg[D];
    assign m_tuser  = err_reg[D];
    assign m_tdata  = M_TDATA_W'({oy_reg[D], ox_reg[D], heading_reg});

    `include "calibrated_compass_heading_assert.svh"

    `CCH_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_tvalid && s_tready, vld_reg[1])
    `CCH_ASSERT_NEXT(a_last_stage_moves, aclk, aresetn, vld_reg[D-1] && adv, m_tvalid)
    `CCH_ASSERT_IMPL(a_error_zero_heading, aclk, aresetn, m_tvalid && m_tuser, heading_reg == '0)

endmodule

// File: verif/tb_calibrated_compass_heading.sv
`timescale 1ns / 100ps
// Self-checking bench for calibrated_compass_heading: streams raw X/Y beats through several
// calibration settings and idling patterns, checking each result beat against a heading
// predictor kept in the bench. Depends on cch_pkg and the RTL top level.
module tb_calibrated_compass_heading;

    localparam int     STAGES      = 16;
    localparam int     CYCLE_LIMIT = 200000;
    localparam int     HOLD_LEN    = 300;
    localparam int     DRAIN_WAIT  = 40;
    localparam int     REPORT_MAX  = 50;
    localparam longint SUB         = 256;
    localparam longint CDEG_360    = 36000;
    localparam longint CDEG_180    = 18000;
    localparam longint NORM_LIMIT  = 64'sd1 <<< 52;

    typedef struct {
        logic [15:0]        heading;
        logic signed [16:0] off_x;
        logic signed [16:0] off_y;
        logic               cal_err;
    } heading_result_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [31:0]                   s_tdata   = '0;    // mag_x, mag_y
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [55:0]                   m_tdata;           // heading_cdeg, offset_x, offset_y
    logic                          m_tuser;           // cal_error
    logic                          cfg_wr_en = 1'b0;
    logic [cch_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]                   cfg_wdata = '0;

    logic signed [15:0] cal_x_min = 16'sh8000;
    logic signed [15:0] cal_x_max = 16'sh7fff;
    logic signed [15:0] cal_y_min = 16'sh8000;
    logic signed [15:0] cal_y_max = 16'sh7fff;
    logic [15:0]        decl_cdeg = cch_pkg::DECL_RESET;

    logic [31:0]     pending_samples[$];
    heading_result_t expected_headings[$];
    heading_result_t due;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_req       = 1'b0;
    int   hold_cycles    = 0;
    int   errors         = 0;
    int   cycle_count    = 0;

    calibrated_compass_heading u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic longint atan_step(int i);
        case (i)
            0:  return 1152000;
            1:  return 680065;
            2:  return 359328;
            3:  return 182400;
            4:  return 91554;
            5:  return 45822;
            6:  return 22916;
            7:  return 11459;
            8:  return 5730;
            9:  return 2865;
            10: return 1432;
            11: return 716;
            12: return 358;
            13: return 179;
            14: return 90;
            15: return 45;
            default: return 0;
        endcase
    endfunction

    function automatic heading_result_t predict_heading(logic [15:0] raw_x, logic [15:0] raw_y);
        heading_result_t r;
        longint sx, sy, ox, oy, span_x, span_y;
        longint vx, vy, nx, ny, mag, ay, ang, deg, hdg;
        sx     = longint'($signed(raw_x));
        sy     = longint'($signed(raw_y));
        ox     = (2 * sx - (longint'(cal_x_min) + longint'(cal_x_max))) / 2;
        oy     = (2 * sy - (longint'(cal_y_min) + longint'(cal_y_max))) / 2;
        span_x = longint'(cal_x_max) - longint'(cal_x_min);
        span_y = longint'(cal_y_max) - longint'(cal_y_min);
        r.off_x   = 17'(ox);
        r.off_y   = 17'(oy);
        r.cal_err = (span_x <= 0) || (span_y <= 0);
        hdg = 0;
        if (!r.cal_err) begin
            vx  = ox * span_y;
            vy  = oy * span_x;
            ang = 0;
            deg = 0;
            if (vx != 0 || vy != 0) begin
                if (vx < 0) begin
                    vx  = -vx;
                    vy  = -vy;
                    ang = CDEG_180 * SUB;
                end
                ay  = (vy < 0) ? -vy : vy;
                mag = (vx > ay) ? vx : ay;
                while (mag < NORM_LIMIT) begin
                    vx  = vx * 2;
                    vy  = vy * 2;
                    mag = mag * 2;
                end
                for (int i = 0; i < STAGES; i++) begin
                    if (vy >= 0) begin
                        nx  = vx + (vy >>> i);
                        ny  = vy - (vx >>> i);
                        ang = ang + atan_step(i);
                    end else begin
                        nx  = vx - (vy >>> i);
                        ny  = vy + (vx >>> i);
                        ang = ang - atan_step(i);
                    end
                    vx = nx;
                    vy = ny;
                end
                deg = (ang + CDEG_360 * SUB + SUB / 2) / SUB - CDEG_360;
                if (deg < 0)
                    deg = deg + CDEG_360;
                if (deg >= CDEG_360)
                    deg = deg - CDEG_360;
            end
            hdg = deg + longint'(decl_cdeg);
            if (hdg > CDEG_360)
                hdg = hdg - CDEG_360;
        end
        r.heading = 16'(hdg);
        return r;
    endfunction

    function automatic void check_field(string what, logic [16:0] want, logic [16:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= REPORT_MAX)
                $display("%0t: %s expected %0d, got %0d", $time, what, $signed(want),
                         $signed(got));
        end
    endfunction

    function automatic logic [15:0] pick_sample(logic signed [15:0] lo, logic signed [15:0] hi);
        int a, b, sel;
        a   = (lo < hi) ? lo : hi;
        b   = (lo < hi) ? hi : lo;
        sel = $urandom_range(9);
        if (sel < 4)
            return 16'($urandom());
        if (sel < 8)
            return 16'(a + int'($urandom_range(b - a)));
        if (sel == 8)
            return 16'((a + b) / 2 + int'($urandom_range(6)) - 3);
        return $urandom_range(1) ? 16'h8000 : 16'h7fff;
    endfunction

    // Driver: predict on acceptance, then offer the next pending beat or idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_headings.push_back(predict_heading(s_tdata[15:0], s_tdata[31:16]));
            if (!s_tvalid || s_tready) begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_samples.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_req && hold_cycles < HOLD_LEN)
            hold_cycles <= hold_cycles + 1;
    end

    // Monitor: compare each result beat with the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_headings.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("%0t: result beat with nothing expected, expected none, got %h",
                                 $time, m_tdata);
                end else begin
                    due = expected_headings.pop_front();
                    check_field("heading_cdeg", {1'b0, due.heading}, {1'b0, m_tdata[15:0]});
                    check_field("offset_x", due.off_x, m_tdata[32:16]);
                    check_field("offset_y", due.off_y, m_tdata[49:33]);
                    check_field("cal_error", {16'd0, due.cal_err}, {16'd0, m_tuser});
                end
            end
            m_tready <= !(hold_req && hold_cycles < HOLD_LEN)
                        && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [cch_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
    endtask

    task automatic apply_calibration(int xmin, int xmax, int ymin, int ymax, int decl);
        write_reg(cch_pkg::REG_X_MIN, 16'(xmin));
        write_reg(cch_pkg::REG_X_MAX, 16'(xmax));
        write_reg(cch_pkg::REG_Y_MIN, 16'(ymin));
        write_reg(cch_pkg::REG_Y_MAX, 16'(ymax));
        write_reg(cch_pkg::REG_DECL, 16'(decl));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cal_x_min = 16'(xmin);
        cal_x_max = 16'(xmax);
        cal_y_min = 16'(ymin);
        cal_y_max = 16'(ymax);
        decl_cdeg = 16'(decl);
    endtask

    task automatic random_calibration();
        int x0, x1, y0, y1, t;
        x0 = int'($urandom_range(65535)) - 32768;
        x1 = int'($urandom_range(65535)) - 32768;
        y0 = int'($urandom_range(65535)) - 32768;
        y1 = int'($urandom_range(65535)) - 32768;
        if ($urandom_range(9) != 0) begin
            if (x0 > x1) begin
                t = x0; x0 = x1; x1 = t;
            end
            if (y0 > y1) begin
                t = y0; y0 = y1; y1 = t;
            end
            if (x0 == x1)
                x0 = x0 - 1;
            if (y0 == y1)
                y0 = y0 - 1;
        end
        apply_calibration(x0, x1, y0, y1, $urandom_range(35999));
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        @(posedge aclk);
        send_idle_pct  <= send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    task automatic push_sample(logic [15:0] x, logic [15:0] y);
        pending_samples.push_back({y, x});
    endtask

    task automatic push_random(int n);
        repeat (n)
            pending_samples.push_back({pick_sample(cal_y_min, cal_y_max),
                                       pick_sample(cal_x_min, cal_x_max)});
    endtask

    task automatic drain();
        while (pending_samples.size() != 0 || s_tvalid || expected_headings.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset calibration: full-scale corners, odd midpoint truncation
        push_sample(16'h8000, 16'h8000);
        push_sample(16'h7fff, 16'h7fff);
        push_sample(16'h8000, 16'h7fff);
        push_sample(16'h7fff, 16'h8000);
        push_sample(16'h0000, 16'h0000);
        push_sample(16'hffff, 16'h0001);
        drain();

        // centered at (0, 50): zero vector, axis directions
        apply_calibration(-100, 100, -50, 150, 0);
        push_sample(16'd0, 16'd50);
        push_sample(16'd0, 16'd100);
        push_sample(16'd0, 16'd0);
        push_sample(-16'sd10, 16'd50);
        push_sample(16'd10, 16'd50);
        push_sample(16'd100, 16'd150);
        push_sample(-16'sd100, -16'sd50);
        push_sample(16'd1, 16'd51);
        push_random(200);
        drain();

        apply_calibration(-32768, 32767, -32768, 32767, 35999);
        set_idling(75, 0);
        push_random(250);
        drain();

        // zero X span: invalid calibration
        apply_calibration(5, 5, -32768, 32767, 0);
        set_idling(0, 75);
        push_sample(16'd5, 16'd0);
        push_sample(16'h7fff, 16'h8000);
        push_random(100);
        drain();

        // inverted Y span
        apply_calibration(-1000, 1000, 200, -200, 18000);
        set_idling(13, 13);
        push_random(100);
        drain();

        // declination above a full turn, then a long output hold-off
        apply_calibration(-300, 300, -300, 300, 65535);
        set_idling(0, 0);
        push_sample(16'd300, 16'd0);
        push_sample(16'd0, 16'd300);
        @(posedge aclk);
        hold_req <= 1'b1;
        push_random(60);
        @(posedge aclk);
        while (hold_cycles < HOLD_LEN)
            @(posedge aclk);
        hold_req <= 1'b0;
        drain();
        set_idling(13, 13);
        push_random(140);
        drain();

        for (int k = 0; k < 4; k++) begin
            random_calibration();
            case (k)
                0: set_idling(0, 0);
                1: set_idling(75, 0);
                2: set_idling(0, 75);
                default: set_idling(13, 13);
            endcase
            push_random(120);
            drain();
        end

        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0 && expected_headings.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: calibrated_compass_heading.f
+incdir+rtl
rtl/cch_pkg.sv
rtl/calibrated_compass_heading.sv
verif/tb_calibrated_compass_heading.sv
